@@ rtl/dfpa_pkg.sv @@
// Shared types, operation codes and constants for the decimal fixed-point ALU.
// No dependencies.
`default_nettype none
package dfpa_pkg;

    typedef enum logic [3:0] {
        FN_ADD = 4'd0,
        FN_SUB = 4'd1,
        FN_MUL = 4'd2,
        FN_DIV = 4'd3,
        FN_LT  = 4'd4,
        FN_EQ  = 4'd5,
        FN_LE  = 4'd6,
        FN_GE  = 4'd7,
        FN_GT  = 4'd8,
        FN_NE  = 4'd9
    } t_func;

    // one restoring-division cell per quotient bit of the 128-bit dividend
    localparam int DIV_STEPS = 128;

    // side data that travels alongside the divider datapath
    typedef struct packed {
        logic        valid;
        logic        use_q;   // result comes from the quotient
        logic        neg;     // quotient gets negated
        logic [63:0] res;     // add/sub result, already wrapped
        logic        cmp;
        logic        dbz;
    } t_side;

    typedef struct packed {
        t_side        side;
        logic [63:0]  rem;
        logic [127:0] num;    // dividend bits on top, quotient bits shift in below
        logic [63:0]  dvs;
    } t_stage;

    function automatic logic [63:0] pow10(input int n);
        logic [63:0] s;
        s = 64'd1;
        for (int i = 0; i < 18; i++) begin
            if (i < n) begin
                s = s * 64'd10;
            end
        end
        return s;
    endfunction

endpackage
`default_nettype wire

@@ rtl/dfpa_if.sv @@
// Valid/ready channel interfaces for operand and result transactions.
// Depends on nothing.
`default_nettype none
interface dfpa_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         func;
    logic signed [63:0] lhs_value;
    logic signed [63:0] rhs_value;
    modport source (output valid, func, lhs_value, rhs_value, input ready);
    modport sink   (input valid, func, lhs_value, rhs_value, output ready);
endinterface

interface dfpa_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] result_value;
    logic               compare_true;
    logic               divide_by_zero;
    logic               overflow;
    modport source (output valid, result_value, compare_true, divide_by_zero, overflow,
                    input ready);
    modport sink   (input valid, result_value, compare_true, divide_by_zero, overflow,
                    output ready);
endinterface
`default_nettype wire

@@ rtl/decimal_fixed_point_alu.sv @@
// Decimal fixed-point ALU top level (values scaled by 10^FRAC_DIGITS).
// Pipeline from accepted operand transaction to result transaction:
// 3 front stages, 128 division cells, 1 output register.
// Throughput: one transaction per cycle; the whole pipe advances together and
// stalls only while the output register holds a result that is not taken.
// Reset: synchronous active-low, clears the valid bits of every stage.
`default_nettype none
module decimal_fixed_point_alu
    import dfpa_pkg::*;
#(
    parameter int FRAC_DIGITS = 9,
    parameter int WORD_BITS   = 64
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    dfpa_in_if.sink     i_op,
    dfpa_out_if.source  o_res
);
    localparam int          SH    = 64 - WORD_BITS;
    localparam logic [63:0] LIMIT = 64'd1 << (WORD_BITS - 1);

    // Global advance: every stage moves when the output slot is free or
    // its result is being taken this cycle.
    logic en;
    logic r_out_valid;
    assign en         = !r_out_valid || o_res.ready;
    assign i_op.ready = en;

    // Front end: operand capture, magnitudes, wide product.
    // For mul the dividend is |a|*|b| over the scale; for div it is
    // |a|*scale over |b|. Both then share the same divider chain.
    t_stage chain [DIV_STEPS + 1];

    dfpa_front #(
        .FRAC_DIGITS(FRAC_DIGITS),
        .WORD_BITS  (WORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_op.valid),
        .i_func  (i_op.func),
        .i_lhs   (i_op.lhs_value),
        .i_rhs   (i_op.rhs_value),
        .o_stage (chain[0])
    );

    // Divider chain: each cell shifts in one quotient bit. After the last
    // cell the num field holds the full 128-bit quotient magnitude.
    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
        dfpa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_stage (chain[g]),
            .o_stage (chain[g + 1])
        );
    end

    // Output stage: apply sign, wrap to word size, check the range.
    t_stage      last;
    logic [63:0] q_lo, q_sgn, q_wrap, lim;
    logic        q_ovf;

    assign last = chain[DIV_STEPS];

    always_comb begin
        q_lo   = last.num[63:0];
        lim    = last.side.neg ? LIMIT : LIMIT - 64'd1;
        q_ovf  = (last.num[127:64] != 64'd0) || (q_lo > lim);
        q_sgn  = last.side.neg ? 64'(64'd0 - q_lo) : q_lo;
        q_wrap = 64'($signed(q_sgn << SH) >>> SH);
    end

    logic [63:0] r_res;
    logic        r_cmp, r_dbz, r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= last.side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res <= last.side.use_q ? q_wrap : last.side.res;
            r_ovf <= last.side.use_q & q_ovf;
            r_cmp <= last.side.cmp;
            r_dbz <= last.side.dbz;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.result_value   = $signed(r_res);
    assign o_res.compare_true   = r_cmp;
    assign o_res.divide_by_zero = r_dbz;
    assign o_res.overflow       = r_ovf;

    // A divide-by-zero transaction carries neither a value nor overflow.
    a_dbz_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.divide_by_zero) |-> (r_res == 64'd0 && !o_res.overflow))
        else $error("divide-by-zero result not clean");

    // Comparison results never flag arithmetic errors.
    a_cmp_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.compare_true) |-> (!o_res.overflow && !o_res.divide_by_zero))
        else $error("compare flag mixed with arithmetic flags");

    // An empty output slot never stalls the input side.
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_op.ready)
        else $error("input stalled with empty output");

endmodule
`default_nettype wire

@@ rtl/dfpa_front.sv @@
// Front end: operand capture, magnitudes, 64x64 product in 32-bit pieces,
// add/sub/compare results. Depends on dfpa_pkg.
`default_nettype none
module dfpa_front
    import dfpa_pkg::*;
#(
    parameter int FRAC_DIGITS = 9,
    parameter int WORD_BITS   = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire logic [3:0]         i_func,
    input  wire logic signed [63:0] i_lhs,
    input  wire logic signed [63:0] i_rhs,
    output t_stage                  o_stage
);
    localparam int          SH    = 64 - WORD_BITS;
    localparam logic [63:0] SCALE = pow10(FRAC_DIGITS);

    function automatic logic [63:0] sext_w(input logic [63:0] v);
        logic signed [63:0] t;
        t = $signed(v << SH);
        return 64'(t >>> SH);
    endfunction

    function automatic logic [63:0] mag(input logic [63:0] v);
        return v[63] ? 64'(64'd0 - v) : v;
    endfunction

    // stage A: sign-extended operands
    logic        r_a_valid, n_a_valid;
    logic [3:0]  r_a_func;
    logic [63:0] r_a_lhs, r_a_rhs;

    assign n_a_valid = i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= n_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_func <= i_func;
            r_a_lhs  <= sext_w(64'(i_lhs));
            r_a_rhs  <= sext_w(64'(i_rhs));
        end
    end

    // stage B: partial products and side results
    t_side       n_b_side;
    logic [63:0] mx, my, n_b_dvs;
    logic        lt, eq;

    always_comb begin
        lt = $signed(r_a_lhs) < $signed(r_a_rhs);
        eq = r_a_lhs == r_a_rhs;
        mx = mag(r_a_lhs);
        n_b_side       = '0;
        n_b_side.valid = r_a_valid;
        n_b_side.neg   = r_a_lhs[63] ^ r_a_rhs[63];
        if (t_func'(r_a_func) == FN_MUL) begin
            my      = mag(r_a_rhs);
            n_b_dvs = SCALE;
        end else begin
            my      = SCALE;
            n_b_dvs = mag(r_a_rhs);
        end
        unique case (t_func'(r_a_func))
            FN_ADD:  n_b_side.res = sext_w(64'(r_a_lhs + r_a_rhs));
            FN_SUB:  n_b_side.res = sext_w(64'(r_a_lhs - r_a_rhs));
            FN_MUL:  n_b_side.use_q = 1'b1;
            FN_DIV: begin
                if (r_a_rhs == 64'd0) begin
                    n_b_side.dbz = 1'b1;
                end else begin
                    n_b_side.use_q = 1'b1;
                end
            end
            FN_LT:   n_b_side.cmp = lt;
            FN_EQ:   n_b_side.cmp = eq;
            FN_LE:   n_b_side.cmp = lt | eq;
            FN_GE:   n_b_side.cmp = ~lt;
            FN_GT:   n_b_side.cmp = ~lt & ~eq;
            FN_NE:   n_b_side.cmp = ~eq;
            default: n_b_side = '{valid: r_a_valid, default: '0};
        endcase
    end

    t_side       r_b_side;
    logic [63:0] r_b_dvs;
    logic [63:0] r_p00, r_p01, r_p10, r_p11;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_side.valid <= 1'b0;
        end else if (i_en) begin
            r_b_side <= n_b_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_dvs <= n_b_dvs;
            r_p00   <= 64'(mx[31:0])  * 64'(my[31:0]);
            r_p01   <= 64'(mx[31:0])  * 64'(my[63:32]);
            r_p10   <= 64'(mx[63:32]) * 64'(my[31:0]);
            r_p11   <= 64'(mx[63:32]) * 64'(my[63:32]);
        end
    end

    // stage C: 128-bit product sum, handed to the first cell
    t_stage r_c, n_c;

    always_comb begin
        n_c      = '0;
        n_c.side = r_b_side;
        n_c.dvs  = r_b_dvs;
        n_c.num  = {r_p11, r_p00} + {32'd0, r_p01, 32'd0} + {32'd0, r_p10, 32'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c.side.valid <= 1'b0;
        end else if (i_en) begin
            r_c <= n_c;
        end
    end

    assign o_stage = r_c;
endmodule
`default_nettype wire

@@ rtl/dfpa_cell.sv @@
// One restoring-division step: one quotient bit per cell, registered.
// Depends on dfpa_pkg.
`default_nettype none
module dfpa_cell
    import dfpa_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_en,
    input  wire t_stage i_stage,
    output t_stage      o_stage
);
    t_stage      r_st, n_st;
    logic [64:0] rem2, diff;
    logic        ge;

    always_comb begin
        rem2 = {i_stage.rem, i_stage.num[127]};
        diff = rem2 - {1'b0, i_stage.dvs};
        ge   = rem2 >= {1'b0, i_stage.dvs};
        n_st      = i_stage;
        n_st.rem  = ge ? diff[63:0] : rem2[63:0];
        n_st.num  = {i_stage.num[126:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.side.valid <= 1'b0;
        end else if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_stage = r_st;
endmodule
`default_nettype wire
